>>> src/yuyv2rgb_pkg.sv
// constants and pixel arithmetic for the yuyv 4:2:2 to rgb888 converter
// no dependencies; used by yuyv_to_rgb_converter_core
package yuyv2rgb_pkg;

    localparam int unsigned ByteWidth = 8;
    localparam int unsigned SumWidth  = 16;

    localparam logic signed [SumWidth-1:0] LumaGain       = 16'sd18;
    localparam logic signed [SumWidth-1:0] ChromaStrong   = 16'sd50;
    localparam logic signed [SumWidth-1:0] ChromaRedGreen = 16'sd25;
    localparam logic signed [SumWidth-1:0] ChromaBlueGreen = 16'sd15;
    localparam logic signed [SumWidth-1:0] LumaOffset     = 16'sd16;
    localparam logic signed [SumWidth-1:0] ChromaMid      = 16'sd128;
    localparam logic signed [SumWidth-1:0] ScaledMax      = 16'sd5100;

    localparam logic [ByteWidth-1:0] ChromaZero    = 8'd0;
    localparam logic [ByteWidth-1:0] ChromaMidByte = 8'd128;
    localparam logic [ByteWidth-1:0] ComponentMax  = 8'd255;
    localparam logic [ByteWidth-1:0] ComponentMin  = 8'd0;

    // x / 20 == (x * 3277) >> 16 for 0 <= x < 5100
    localparam int unsigned ScaledBits  = 13;
    localparam int unsigned RecipBits   = 12;
    localparam int unsigned RecipShift  = 16;
    localparam int unsigned ProdBits    = ScaledBits + RecipBits;
    localparam logic [RecipBits-1:0] RecipMul = 12'd3277;

    typedef struct packed {
        logic [ByteWidth-1:0] red;
        logic [ByteWidth-1:0] green;
        logic [ByteWidth-1:0] blue;
    } rgb_t;

    function automatic logic [ByteWidth-1:0] scaled_to_byte(
        input logic signed [SumWidth-1:0] scaled
    );
        logic [ProdBits-1:0] prod;
        prod = {{RecipBits{1'b0}}, scaled[ScaledBits-1:0]}
             * {{ScaledBits{1'b0}}, RecipMul};
        if (scaled < 0) begin
            return ComponentMin;
        end
        if (scaled >= ScaledMax) begin
            return ComponentMax;
        end
        return prod[RecipShift +: ByteWidth];
    endfunction

    function automatic logic signed [SumWidth-1:0] center_chroma(
        input logic [ByteWidth-1:0] chroma
    );
        logic [ByteWidth-1:0] fixed;
        fixed = (chroma == ChromaZero) ? ChromaMidByte : chroma;
        return $signed({{(SumWidth-ByteWidth){1'b0}}, fixed}) - ChromaMid;
    endfunction

    function automatic rgb_t make_pixel(
        input logic [ByteWidth-1:0] luma,
        input logic [ByteWidth-1:0] chroma_u,
        input logic [ByteWidth-1:0] chroma_v
    );
        logic signed [SumWidth-1:0] ucen;
        logic signed [SumWidth-1:0] vcen;
        logic signed [SumWidth-1:0] base;
        logic signed [SumWidth-1:0] red_sum;
        logic signed [SumWidth-1:0] green_sum;
        logic signed [SumWidth-1:0] blue_sum;
        rgb_t pix;
        ucen = center_chroma(chroma_u);
        vcen = center_chroma(chroma_v);
        base = LumaGain * ($signed({{(SumWidth-ByteWidth){1'b0}}, luma}) - LumaOffset);
        red_sum   = base + ChromaStrong * vcen;
        green_sum = base - ChromaRedGreen * vcen - ChromaBlueGreen * ucen;
        blue_sum  = base + ChromaStrong * ucen;
        pix.red   = scaled_to_byte(red_sum);
        pix.green = scaled_to_byte(green_sum);
        pix.blue  = scaled_to_byte(blue_sum);
        return pix;
    endfunction

endpackage

>>> src/yuyv_to_rgb_converter_core.sv
// yuyv 4:2:2 group to rgb888 pixel pair converter, top level
// depends on yuyv2rgb_pkg for constants and pixel arithmetic
//
// usage:
//   input channel (in_valid/in_ready) carries one request: a yuyv group
//   of luma_first, chroma_blue (u), luma_second, chroma_red (v).
//   output channel (out_valid/out_ready) carries two rgb pixels per request:
//   first the pixel from luma_first, then the one from luma_second with
//   last_pixel set. both share the group's chroma.
//   a group accepted into the input register reaches the output register
//   as its first pixel; its second pixel loads into the output register
//   at the edge at which the first is taken.
//   throughput: 1 pixel per cycle while out_ready stays high, set by the
//   single output register that holds one pixel at a time.
//   the input register holds the group while its pixels pass through the
//   output register, so a new group is taken in the cycle its
//   predecessor's second pixel moves to the output.
//   reset clears both valid flags; no request is held afterwards.
//   when the receiver stalls, the output pixel holds and the input
//   register fills, after which in_ready stays low.
module yuyv_to_rgb_converter_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] luma_first,
    input  logic [7:0] chroma_blue,
    input  logic [7:0] luma_second,
    input  logic [7:0] chroma_red,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic       last_pixel
);

    logic       stage_valid_reg;
    logic       stage_valid_next;
    logic       phase_reg;
    logic       phase_next;
    logic [7:0] luma_first_reg;
    logic [7:0] luma_second_reg;
    logic [7:0] chroma_blue_reg;
    logic [7:0] chroma_red_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic       last_reg;
    yuyv2rgb_pkg::rgb_t pix_reg;
    yuyv2rgb_pkg::rgb_t pix_next;

    logic       in_take;
    logic       out_load;
    logic       stage_done;
    logic [7:0] sel_luma;

    assign out_load   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign stage_done = out_load && phase_reg;
    assign in_ready   = !stage_valid_reg || stage_done;
    assign in_take    = in_valid && in_ready;

    assign sel_luma = phase_reg ? luma_second_reg : luma_first_reg;
    assign pix_next = yuyv2rgb_pkg::make_pixel(sel_luma, chroma_blue_reg, chroma_red_reg);

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_done)
        begin
            stage_valid_next = 1'b0;
        end

        phase_next = phase_reg;
        if (in_take || stage_done)
        begin
            phase_next = 1'b0;
        end
        else if (out_load)
        begin
            phase_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            phase_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            phase_reg       <= phase_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            luma_first_reg  <= luma_first;
            luma_second_reg <= luma_second;
            chroma_blue_reg <= chroma_blue;
            chroma_red_reg  <= chroma_red;
        end
        if (out_load)
        begin
            pix_reg  <= pix_next;
            last_reg <= phase_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red        = pix_reg.red;
    assign green      = pix_reg.green;
    assign blue       = pix_reg.blue;
    assign last_pixel = last_reg;

    // first pixel on the output means its group still waits for the second
    a_first_holds_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> stage_valid_reg && phase_reg)
        else $error("first pixel shown without its group held");

    // a group whose first pixel is not yet sent blocks the input
    a_no_take_mid_group: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !phase_reg |-> !in_ready)
        else $error("input taken while a group is unsent");

    // retiring a group puts its second pixel on the output
    a_done_shows_last: assert property (@(posedge clk) disable iff (!rst_n)
        stage_done |=> out_valid_reg && last_reg)
        else $error("second pixel missing after group retired");

    // a new request starts with its first pixel
    a_take_starts_first: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> stage_valid_reg && !phase_reg)
        else $error("new request not started on its first pixel");

endmodule

>>> verif/tb.sv
// self-checking testbench for yuyv_to_rgb_converter_core
// drives yuyv groups and checks each rgb pixel against a local integer predictor
// depends only on the rtl: yuyv2rgb_pkg and yuyv_to_rgb_converter_core
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LUMA_GAIN = 18;
    localparam int CHROMA_STRONG = 50;
    localparam int CHROMA_RED_GREEN = 25;
    localparam int CHROMA_BLUE_GREEN = 15;
    localparam int LUMA_OFFSET = 16;
    localparam int CHROMA_CENTER = 128;
    localparam int SCALE = 20;
    localparam int BYTE_MAX = 255;
    localparam int RANDOM_PER_PHASE = 610;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;

    pixel_t pending_pixels[$];
    pixel_t wanted;
    int     mismatch_count;
    int     cycle_count;
    int     send_idle_pct;
    int     recv_idle_pct;

    yuyv_to_rgb_converter_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .luma_first (luma_first),
        .chroma_blue(chroma_blue),
        .luma_second(luma_second),
        .chroma_red (chroma_red),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .last_pixel (last_pixel)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [7:0] clamp_component(input int scaled);
        if (scaled < 0)
        begin
            return 8'd0;
        end
        if (scaled >= BYTE_MAX * SCALE)
        begin
            return 8'(BYTE_MAX);
        end
        return 8'(scaled / SCALE);
    endfunction

    function automatic pixel_t convert_pixel(input logic [7:0] luma, input logic [7:0] u,
                                             input logic [7:0] v, input logic last);
        int     u_off;
        int     v_off;
        int     base;
        pixel_t pix;
        u_off = (u == 8'd0) ? 0 : int'(u) - CHROMA_CENTER;
        v_off = (v == 8'd0) ? 0 : int'(v) - CHROMA_CENTER;
        base = LUMA_GAIN * (int'(luma) - LUMA_OFFSET);
        pix.red = clamp_component(base + CHROMA_STRONG * v_off);
        pix.green = clamp_component(base - CHROMA_RED_GREEN * v_off - CHROMA_BLUE_GREEN * u_off);
        pix.blue = clamp_component(base + CHROMA_STRONG * u_off);
        pix.last = last;
        return pix;
    endfunction

    function automatic logic [7:0] random_byte(input bit is_chroma);
        int mode;
        mode = $urandom_range(0, 15);
        if (mode == 0 || (is_chroma && mode == 1))
        begin
            return 8'd0;
        end
        if (mode == 2)
        begin
            return 8'd255;
        end
        if (mode == 3)
        begin
            return is_chroma ? 8'(CHROMA_CENTER) : 8'(LUMA_OFFSET);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // caller is at a falling edge; returns at a falling edge
    task automatic send_group(input logic [7:0] y0, input logic [7:0] u,
                              input logic [7:0] y1, input logic [7:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            luma_first <= 8'($urandom);
            chroma_blue <= 8'($urandom);
            luma_second <= 8'($urandom);
            chroma_red <= 8'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        luma_first <= y0;
        chroma_blue <= u;
        luma_second <= y1;
        chroma_red <= v;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_pixels.push_back(convert_pixel(y0, u, v, 1'b0));
        pending_pixels.push_back(convert_pixel(y1, u, v, 1'b1));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic test_extremes();
        send_group(8'd0, 8'd1, 8'd255, 8'd1);
        send_group(8'd255, 8'd255, 8'd0, 8'd255);
        send_group(8'd0, 8'd255, 8'd255, 8'd1);
        send_group(8'd255, 8'd1, 8'd0, 8'd255);
        send_group(8'd16, 8'd127, 8'd235, 8'd129);
        send_group(8'hAA, 8'h55, 8'h55, 8'hAA);
    endtask

    task automatic test_zero_chroma();
        send_group(8'd0, 8'd0, 8'd255, 8'd0);
        send_group(8'd128, 8'd0, 8'd16, 8'd200);
        send_group(8'd100, 8'd60, 8'd200, 8'd0);
        send_group(8'd16, 8'd128, 8'd17, 8'd128);
    endtask

    task automatic test_clamping();
        send_group(8'd0, 8'd1, 8'd10, 8'd1);
        send_group(8'd255, 8'd255, 8'd240, 8'd250);
        send_group(8'd50, 8'd255, 8'd60, 8'd1);
        send_group(8'd235, 8'd1, 8'd200, 8'd255);
    endtask

    task automatic test_fraction();
        send_group(8'd17, 8'd128, 8'd27, 8'd128);
        send_group(8'd38, 8'd129, 8'd39, 8'd127);
        send_group(8'd100, 8'd131, 8'd101, 8'd125);
    endtask

    task automatic test_drain_pause();
        repeat (4)
        begin
            send_group(random_byte(1'b0), random_byte(1'b1), random_byte(1'b0),
                       random_byte(1'b1));
        end
        wait_drained();
        repeat (4)
        begin
            send_group(random_byte(1'b0), random_byte(1'b1), random_byte(1'b0),
                       random_byte(1'b1));
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (RANDOM_PER_PHASE)
        begin
            send_group(random_byte(1'b0), random_byte(1'b1), random_byte(1'b0),
                       random_byte(1'b1));
        end
    endtask

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel: red %0d green %0d blue %0d last %0b",
                       red, green, blue, last_pixel);
                mismatch_count++;
            end
            else
            begin
                wanted = pending_pixels.pop_front();
                if (red !== wanted.red)
                begin
                    $error("red: expected %0d, actual %0d", wanted.red, red);
                    mismatch_count++;
                end
                if (green !== wanted.green)
                begin
                    $error("green: expected %0d, actual %0d", wanted.green, green);
                    mismatch_count++;
                end
                if (blue !== wanted.blue)
                begin
                    $error("blue: expected %0d, actual %0d", wanted.blue, blue);
                    mismatch_count++;
                end
                if (last_pixel !== wanted.last)
                begin
                    $error("last_pixel: expected %0b, actual %0b", wanted.last, last_pixel);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        mismatch_count = 0;
        send_idle_pct = 11;
        recv_idle_pct = 83;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        luma_first = 8'd0;
        chroma_blue = 8'd0;
        luma_second = 8'd0;
        chroma_red = 8'd0;
        repeat (6)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_extremes();
        test_zero_chroma();
        test_clamping();
        test_fraction();
        test_drain_pause();
        test_random_traffic(11, 83);
        test_random_traffic(83, 11);
        test_random_traffic(0, 0);

        wait_drained();
        repeat (TAIL_CYCLES)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0 && pending_pixels.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> sim.f
src/yuyv2rgb_pkg.sv
src/yuyv_to_rgb_converter_core.sv
verif/tb.sv
